// File: hdl/imufd_pkg.sv
// Shared constants and tables for the inertial frame decoder with gravity compensation.
// Holds frame identifiers, kind codes, field offsets and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package imufd_pkg;

   localparam logic [28:0] ID_ACCEL    = 29'h0CF02D59;
   localparam logic [28:0] ID_GYRO     = 29'h0CF02A59;
   localparam logic [28:0] ID_QUAT     = 29'h0CF03059;
   localparam logic [28:0] ID_ATTITUDE = 29'h0CF02959;

   localparam logic [1:0] KIND_ACCEL    = 2'd0;
   localparam logic [1:0] KIND_GYRO     = 2'd1;
   localparam logic [1:0] KIND_QUAT     = 2'd2;
   localparam logic [1:0] KIND_ATTITUDE = 2'd3;

   localparam logic [17:0] GRAVITY_RESET = 18'd97683;
   localparam int TRIG_BITS_DEFAULT = 16;
   localparam int TRIG_BITS_MAX     = 24;

   localparam logic signed [20:0] OFS_16  = 21'sd32000;
   localparam logic signed [20:0] OFS_Q   = 21'sd32768;
   localparam logic signed [20:0] OFS_20  = 21'sd512000;

   localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
   localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
   localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;
   localparam logic signed [21:0] DEG128_TO_RAD30 = 22'sd146409;
   localparam logic signed [33:0] CORDIC_START    = 34'sd652032874;

   // floor(t / 100) == (t * RECIP_100) >> RECIP_SHIFT for t below 2^20
   localparam logic signed [21:0] RECIP_100   = 22'sd671089;
   localparam int                 RECIP_SHIFT = 26;

   function automatic logic signed [33:0] atan_of(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         default: v = 32'h0;
      endcase
      return $signed({2'b00, v});
   endfunction

endpackage

// File: hdl/imu_frame_decode_gravity_comp_unit.sv
// Top level of the inertial frame decoder with gravity compensation.
// Depends on imufd_pkg for identifiers, kind codes and the arctangent table.
`timescale 1ns / 1ps

// Decodes one sensor bus frame per item: frame_id on req_tuser selects
// acceleration, angular rate, quaternion or attitude, the 64-bit payload on
// req_tdata is split into offset-corrected signed fields. Attitude frames also
// update the stored pitch, roll and yaw. Unknown identifiers produce no result.
// Non-acceleration frames go straight to the output register.
// An acceleration frame runs a sequencer around one shared 34x22 multiplier:
// three CORDIC sine/cosine evaluations of the stored angles, each of
// min(TRIG_BITS,24) iterations, then the rotation-matrix products and
// gravity scaling. req_tready is low while the sequencer runs; a finished
// result waits in the output register.
module imu_frame_decode_gravity_comp_unit #(
   parameter int TRIG_BITS = imufd_pkg::TRIG_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // payload[63:0]
   input  logic [28:0]  req_tuser,   // frame_id[28:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // value_a[20:0], value_b[41:21], value_c[62:42], value_d[78:63],
   // comp_x[95:79], comp_y[112:96], comp_z[129:113], zero fill to 135
   output logic [135:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // frame_kind[1:0]
   input  logic         csr_wr_en,
   input  logic [17:0]  csr_wr_data  // gravity_magnitude
);

   localparam int ITERS = (TRIG_BITS > imufd_pkg::TRIG_BITS_MAX) ?
                          imufd_pkg::TRIG_BITS_MAX : TRIG_BITS;
   localparam logic [4:0] LAST_ITER = 5'(ITERS - 1);
   localparam logic [4:0] LAST_STEP = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE, ST_TRIG_PRE, ST_TRIG_LOAD, ST_TRIG_ITER, ST_TRIG_END, ST_PROD
   } state_type;

   state_type state_ff;
   logic [1:0]  ang_ff;
   logic [4:0]  iter_ff;
   logic [4:0]  step_ff;
   logic [17:0] grav_ff;

   logic signed [16:0] pitch_ff, roll_ff, yaw_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic               neg_ff;
   logic signed [15:0] sin_ff [3];
   logic signed [15:0] cos_ff [3];

   logic signed [55:0] prod_ff, t1_ff;
   logic signed [33:0] r02_ff, r12_ff, r22_ff;
   logic [19:0]        tq_ff;
   logic               gneg_ff;

   logic signed [20:0] ha_ff, hb_ff, hc_ff;
   logic signed [16:0] hx_ff, hy_ff;

   logic               rsp_valid_ff;
   logic [1:0]         kind_ff;
   logic signed [20:0] va_ff, vb_ff, vc_ff;
   logic signed [15:0] vd_ff;
   logic signed [16:0] cx_ff, cy_ff, cz_ff;

   logic signed [33:0] mul_a;
   logic signed [21:0] mul_b;
   logic signed [55:0] prod_in;

   logic               req_fire;
   logic signed [20:0] f0, f1, f2, f3;
   logic signed [20:0] g0, g1, g2;

   logic signed [16:0] ang_cur;
   logic signed [17:0] ang_wrap, ang_fold;
   logic               ang_neg;

   logic signed [33:0] dx, dy, atan_i;
   logic signed [55:0] r02_sum, r12_sum, gmag, gsum;
   logic signed [16:0] gq_signed;

   function automatic logic signed [15:0] q30_to_q15(input logic signed [33:0] v,
                                                     input logic neg);
      logic signed [34:0] r;
      r = ($signed({v[33], v}) + 35'sd16384) >>> 15;
      if (neg) begin
         r = -r;
      end
      if (r > 35'sd32767) begin
         r = 35'sd32767;
      end else if (r < -35'sd32768) begin
         r = -35'sd32768;
      end
      return r[15:0];
   endfunction

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   // 16-bit and 20-bit fields; 32000 or 32768, or 512000, is subtracted on capture
   assign f0 = $signed({5'b0, req_tdata[15:0]});
   assign f1 = $signed({5'b0, req_tdata[31:16]});
   assign f2 = $signed({5'b0, req_tdata[47:32]});
   assign f3 = $signed({5'b0, req_tdata[63:48]});
   assign g0 = $signed({1'b0, req_tdata[19:0]});
   assign g1 = $signed({1'b0, req_tdata[39:20]});
   assign g2 = $signed({1'b0, req_tdata[59:40]});

   // Wrap into a half turn each way, then fold beyond a quarter turn
   always_comb begin
      case (ang_ff)
         2'd0:    ang_cur = pitch_ff;
         2'd1:    ang_cur = roll_ff;
         default: ang_cur = yaw_ff;
      endcase
      ang_wrap = {ang_cur[16], ang_cur};
      if (ang_wrap >= imufd_pkg::HALF_TURN) begin
         ang_wrap = ang_wrap - imufd_pkg::FULL_TURN;
      end
      if (ang_wrap < -imufd_pkg::HALF_TURN) begin
         ang_wrap = ang_wrap + imufd_pkg::FULL_TURN;
      end
      ang_fold = ang_wrap;
      ang_neg  = 1'b0;
      if (ang_wrap > imufd_pkg::QUARTER_TURN) begin
         ang_fold = ang_wrap - imufd_pkg::HALF_TURN;
         ang_neg  = 1'b1;
      end else if (ang_wrap < -imufd_pkg::QUARTER_TURN) begin
         ang_fold = ang_wrap + imufd_pkg::HALF_TURN;
         ang_neg  = 1'b1;
      end
   end

   assign dx     = y_ff >>> iter_ff;
   assign dy     = x_ff >>> iter_ff;
   assign atan_i = imufd_pkg::atan_of(iter_ff);

   assign r02_sum = (t1_ff <<< 15) + prod_ff + 56'sd16384;
   assign r12_sum = t1_ff - (prod_ff <<< 15) + 56'sd16384;
   assign gmag    = prod_ff[55] ? -prod_ff : prod_ff;
   assign gsum    = gmag + (56'sd50 <<< 30);
   assign gq_signed = gneg_ff ? -$signed({1'b0, prod_ff[41:26]})
                              : $signed({1'b0, prod_ff[41:26]});

   // Operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_TRIG_PRE) begin
         mul_a = 34'(ang_fold);
         mul_b = imufd_pkg::DEG128_TO_RAD30;
      end else if (state_ff == ST_PROD) begin
         case (step_ff)
            5'd0:  begin mul_a = 34'(sin_ff[1]); mul_b = 22'(sin_ff[2]); end
            5'd1:  begin mul_a = 34'(cos_ff[1]); mul_b = 22'(cos_ff[2]); end
            5'd2:  begin mul_a = prod_ff[33:0];  mul_b = 22'(sin_ff[0]); end
            5'd3:  begin mul_a = 34'(sin_ff[2]); mul_b = 22'(sin_ff[0]); end
            5'd4:  begin mul_a = prod_ff[33:0];  mul_b = 22'(cos_ff[1]); end
            5'd5:  begin mul_a = 34'(cos_ff[2]); mul_b = 22'(sin_ff[1]); end
            5'd6:  begin mul_a = 34'(cos_ff[0]); mul_b = 22'(cos_ff[1]); end
            5'd7:  begin mul_a = r12_ff; mul_b = $signed({4'b0, grav_ff}); end
            5'd9:  begin mul_a = $signed({14'b0, tq_ff}); mul_b = imufd_pkg::RECIP_100; end
            5'd10: begin mul_a = r02_ff; mul_b = $signed({4'b0, grav_ff}); end
            5'd12: begin mul_a = $signed({14'b0, tq_ff}); mul_b = imufd_pkg::RECIP_100; end
            5'd13: begin mul_a = r22_ff; mul_b = $signed({4'b0, grav_ff}); end
            5'd15: begin mul_a = $signed({14'b0, tq_ff}); mul_b = imufd_pkg::RECIP_100; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ang_ff       <= '0;
         iter_ff      <= '0;
         step_ff      <= '0;
         grav_ff      <= imufd_pkg::GRAVITY_RESET;
         pitch_ff     <= '0;
         roll_ff      <= '0;
         yaw_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            grav_ff <= csr_wr_data;
         end
         // an accepted item either finds the output empty or drains it this edge
         if (rsp_valid_ff && rsp_tready && !req_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  va_ff <= '0; vb_ff <= '0; vc_ff <= '0; vd_ff <= '0;
                  cx_ff <= '0; cy_ff <= '0; cz_ff <= '0;
                  case (req_tuser)
                     imufd_pkg::ID_ACCEL: begin
                        ha_ff        <= f0 - imufd_pkg::OFS_16;
                        hb_ff        <= f1 - imufd_pkg::OFS_16;
                        hc_ff        <= f2 - imufd_pkg::OFS_16;
                        ang_ff       <= 2'd0;
                        rsp_valid_ff <= 1'b0;
                        state_ff     <= ST_TRIG_PRE;
                     end
                     imufd_pkg::ID_GYRO: begin
                        kind_ff      <= imufd_pkg::KIND_GYRO;
                        va_ff        <= g0 - imufd_pkg::OFS_20;
                        vb_ff        <= g1 - imufd_pkg::OFS_20;
                        vc_ff        <= g2 - imufd_pkg::OFS_20;
                        rsp_valid_ff <= 1'b1;
                     end
                     imufd_pkg::ID_QUAT: begin
                        kind_ff      <= imufd_pkg::KIND_QUAT;
                        va_ff        <= f0 - imufd_pkg::OFS_Q;
                        vb_ff        <= f1 - imufd_pkg::OFS_Q;
                        vc_ff        <= f2 - imufd_pkg::OFS_Q;
                        vd_ff        <= 16'(f3 - imufd_pkg::OFS_Q);
                        rsp_valid_ff <= 1'b1;
                     end
                     imufd_pkg::ID_ATTITUDE: begin
                        kind_ff      <= imufd_pkg::KIND_ATTITUDE;
                        va_ff        <= f0 - imufd_pkg::OFS_16;
                        vb_ff        <= f1 - imufd_pkg::OFS_16;
                        vc_ff        <= f2 - imufd_pkg::OFS_16;
                        pitch_ff     <= 17'(f0 - imufd_pkg::OFS_16);
                        roll_ff      <= 17'(f1 - imufd_pkg::OFS_16);
                        yaw_ff       <= 17'(f2 - imufd_pkg::OFS_16);
                        rsp_valid_ff <= 1'b1;
                     end
                     default: begin
                        // unknown frame: drop
                        rsp_valid_ff <= 1'b0;
                     end
                  endcase
               end
            end
            ST_TRIG_PRE: begin
               neg_ff   <= ang_neg;
               state_ff <= ST_TRIG_LOAD;
            end
            ST_TRIG_LOAD: begin
               z_ff     <= prod_ff[33:0];
               x_ff     <= imufd_pkg::CORDIC_START;
               y_ff     <= '0;
               iter_ff  <= '0;
               state_ff <= ST_TRIG_ITER;
            end
            ST_TRIG_ITER: begin
               if (!z_ff[33]) begin
                  x_ff <= x_ff - dx;
                  y_ff <= y_ff + dy;
                  z_ff <= z_ff - atan_i;
               end else begin
                  x_ff <= x_ff + dx;
                  y_ff <= y_ff - dy;
                  z_ff <= z_ff + atan_i;
               end
               if (iter_ff == LAST_ITER) begin
                  state_ff <= ST_TRIG_END;
               end else begin
                  iter_ff <= iter_ff + 5'd1;
               end
            end
            ST_TRIG_END: begin
               sin_ff[ang_ff] <= q30_to_q15(y_ff, neg_ff);
               cos_ff[ang_ff] <= q30_to_q15(x_ff, neg_ff);
               if (ang_ff == 2'd2) begin
                  step_ff  <= '0;
                  state_ff <= ST_PROD;
               end else begin
                  ang_ff   <= ang_ff + 2'd1;
                  state_ff <= ST_TRIG_PRE;
               end
            end
            ST_PROD: begin
               if (step_ff != LAST_STEP) begin
                  step_ff <= step_ff + 5'd1;
               end
               case (step_ff)
                  5'd1: t1_ff  <= prod_ff;
                  5'd3: r02_ff <= r02_sum[48:15];
                  5'd5: t1_ff  <= prod_ff;
                  5'd6: r12_ff <= r12_sum[48:15];
                  5'd7: r22_ff <= prod_ff[33:0];
                  5'd8, 5'd11, 5'd14: begin
                     tq_ff   <= gsum[49:30];
                     gneg_ff <= prod_ff[55];
                  end
                  5'd10: hx_ff <= 17'(ha_ff) + gq_signed;
                  5'd13: hy_ff <= 17'(hb_ff) - gq_signed;
                  5'd16: begin
                     // hold until the output register is free
                     if (!rsp_valid_ff || rsp_tready) begin
                        kind_ff      <= imufd_pkg::KIND_ACCEL;
                        va_ff        <= ha_ff;
                        vb_ff        <= hb_ff;
                        vc_ff        <= hc_ff;
                        vd_ff        <= '0;
                        cx_ff        <= hx_ff;
                        cy_ff        <= hy_ff;
                        cz_ff        <= 17'(hc_ff) - gq_signed;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {6'b0, cz_ff, cy_ff, cx_ff, vd_ff, vc_ff, vb_ff, va_ff};

`ifndef SYNTHESIS
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("input accepted while sequencer busy");
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRIG_ITER) |-> (iter_ff <= LAST_ITER))
      else $error("CORDIC iteration counter out of range");
   a_unknown_drop: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !rsp_valid_ff && req_tuser != imufd_pkg::ID_ACCEL &&
       req_tuser != imufd_pkg::ID_GYRO && req_tuser != imufd_pkg::ID_QUAT &&
       req_tuser != imufd_pkg::ID_ATTITUDE) |=> !rsp_valid_ff)
      else $error("unknown frame produced a result");
   a_comp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != imufd_pkg::KIND_ACCEL) |->
      (cx_ff == 17'sd0 && cy_ff == 17'sd0 && cz_ff == 17'sd0))
      else $error("compensated axes nonzero for non-acceleration item");
`endif

endmodule
